[rtl/mbrs_pkg.sv]
`timescale 1ns / 1ps
package mbrs_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // input actions
    localparam logic [2:0] ACT_RX_BYTE = 3'd0;
    localparam logic [2:0] ACT_GAP     = 3'd1;
    localparam logic [2:0] ACT_TICK    = 3'd2;
    localparam logic [2:0] ACT_HWRITE  = 3'd3;
    localparam logic [2:0] ACT_HREAD   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_HREAD  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SLAVE   = 2'd0;
    localparam logic [1:0] REG_BASE    = 2'd1;
    localparam logic [1:0] REG_INUSE   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // function and exception codes
    localparam logic [7:0] FN_READ_HOLD  = 8'd3;
    localparam logic [7:0] FN_WRITE_ONE  = 8'd6;
    localparam logic [7:0] FN_WRITE_MANY = 8'd16;
    localparam logic [7:0] FN_EXC_FLAG   = 8'h80;
    localparam logic [7:0] EXC_FUNCTION  = 8'd1;
    localparam logic [7:0] EXC_ADDRESS   = 8'd2;
    localparam logic [7:0] EXC_VALUE     = 8'd3;

    localparam int WRITE_QTY_MAX = 123;
    localparam int OUT_LIMIT     = 64;

    // one byte of CRC-16, bit by bit
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0] din);
        logic [15:0] c;
        c = crc_in ^ {8'h00, din};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/mbrs_ram.sv]
`timescale 1ns / 1ps
module mbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/mbrs_crc.sv]
`timescale 1ns / 1ps
module mbrs_crc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        clr,
    input  logic        upd,
    input  logic [7:0]  din,
    output logic [15:0] crc
);
    import mbrs_pkg::*;

    logic [15:0] crc_reg, crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (clr) begin
            crc_next = CRC_INIT;
        end else if (upd) begin
            crc_next = crc_step(crc_reg, din);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;
endmodule

[rtl/modbus_rtu_register_slave.sv]
`timescale 1ns / 1ps
// Channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tuser action, tdata byte/index/value
// m_axis    | out | m_axis_tvalid/tready   | tuser kind, tlast, tdata byte/alarm/value
// apb       | in  | psel/penable/pready    | 4 registers at byte addresses 0,4,8,12
//
// Steps: a received byte, host write or tick is taken in S_IDLE; a host read adds S_HREAD.
// Frame gap: each frame byte is read through the frame RAM read port for the CRC
//   scan (S_SCAN_A, S_SCAN_B), then a decode state, then each header or CRC byte,
//   each table word read (two reply bytes) and each word written (S_W_A to S_W_C).
// Reset: synchronous, clears control state, table valid bits and the alarm.
// Stalls: m_axis_tready low holds the sequencer; s_axis_tready is low while
//   a frame or host read is handled or the output register cannot take a new result.
module modbus_rtu_register_slave #(
    parameter int FRAME_BYTES = mbrs_pkg::FRAME_BYTES_DEF,
    parameter int TABLE_DEPTH = mbrs_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // rx_byte[7:0], local_index[13:8], local_value[29:14]
    input  logic [2:0]  s_axis_tuser,  // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // tx_byte[7:0], alarm[8], read_value[24:9]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbrs_pkg::*;

    localparam int FW = $clog2(FRAME_BYTES);
    localparam int LW = $clog2(FRAME_BYTES + 1);
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CAP_A = ((FRAME_BYTES - 5) / 2 < 125) ? (FRAME_BYTES - 5) / 2 : 125;
    localparam int READ_CAP = ((OUT_LIMIT - 5) / 2 < CAP_A) ? (OUT_LIMIT - 5) / 2 : CAP_A;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HREAD  = 4'd1;
    localparam logic [3:0] S_SCAN_A = 4'd2;
    localparam logic [3:0] S_SCAN_B = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_W_A    = 4'd5;
    localparam logic [3:0] S_W_B    = 4'd6;
    localparam logic [3:0] S_W_C    = 4'd7;
    localparam logic [3:0] S_HDR    = 4'd8;
    localparam logic [3:0] S_T_A    = 4'd9;
    localparam logic [3:0] S_T_H    = 4'd10;
    localparam logic [3:0] S_T_L    = 4'd11;
    localparam logic [3:0] S_CRC_LO = 4'd12;
    localparam logic [3:0] S_CRC_HI = 4'd13;

    // payload fields
    logic [2:0]  in_action;
    logic [7:0]  in_byte;
    logic [5:0]  in_index;
    logic [15:0] in_value;
    assign in_action = s_axis_tuser;
    assign in_byte   = s_axis_tdata[7:0];
    assign in_index  = s_axis_tdata[13:8];
    assign in_value  = s_axis_tdata[29:14];

    // configuration registers
    logic [7:0]  slave_reg;
    logic [15:0] base_reg;
    logic [6:0]  inuse_reg;
    logic [31:0] timeout_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_reg   <= 8'd1;
            base_reg    <= 16'd0;
            inuse_reg   <= 7'd64;
            timeout_reg <= 32'd1000;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SLAVE:   slave_reg   <= pwdata[7:0];
                REG_BASE:    base_reg    <= pwdata[15:0];
                REG_INUSE:   inuse_reg   <= pwdata[6:0];
                REG_TIMEOUT: timeout_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SLAVE:   prdata = {24'd0, slave_reg};
            REG_BASE:    prdata = {16'd0, base_reg};
            REG_INUSE:   prdata = {25'd0, inuse_reg};
            REG_TIMEOUT: prdata = timeout_reg;
            default:     prdata = 32'd0;
        endcase
    end

    // state
    logic [3:0]  state_reg, state_next;
    logic [LW-1:0] flen_reg, flen_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [31:0] ticks_reg, ticks_next;
    logic        alarm_reg, alarm_next;
    logic [TABLE_DEPTH-1:0] tv_reg, tv_next;
    logic [7:0]  hdr_reg [6];
    logic [7:0]  hdr_next [6];
    logic [2:0]  hlen_reg, hlen_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] qty_reg, qty_next;
    logic [7:0]  bc_reg, bc_next;
    logic [7:0]  rxlo_reg, rxlo_next;
    logic [7:0]  rxhi_reg, rxhi_next;
    logic [7:0]  whi_reg, whi_next;
    logic [15:0] word_reg, word_next;
    logic        rdm_reg, rdm_next;
    logic        hok_reg, hok_next;
    logic        tvr_reg, tvr_next;

    // output register
    logic        mv_reg;
    logic [1:0]  mkind_reg;
    logic [7:0]  mbyte_reg;
    logic        mlast_reg;
    logic        malarm_reg;
    logic [15:0] mval_reg;

    logic        out_free;
    logic        emit;
    logic [1:0]  e_kind;
    logic [7:0]  e_byte;
    logic        e_last;
    logic        e_alarm;
    logic [15:0] e_val;

    // memories
    logic          fr_we;
    logic [FW-1:0] fr_waddr, fr_raddr;
    logic [7:0]    fr_rdata;
    logic          tb_we;
    logic [TW-1:0] tb_waddr, tb_raddr;
    logic [15:0]   tb_wdata, tb_rdata;

    // crc unit
    logic        crc_clr, crc_upd;
    logic [7:0]  crc_din;
    logic [15:0] crc;

    mbrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES), .AW(FW)) u_frame (
        .aclk(aclk), .we(fr_we), .waddr(fr_waddr), .wdata(in_byte),
        .raddr(fr_raddr), .rdata(fr_rdata)
    );

    mbrs_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH), .AW(TW)) u_table (
        .aclk(aclk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
        .raddr(tb_raddr), .rdata(tb_rdata)
    );

    mbrs_crc u_crc (
        .aclk(aclk), .aresetn(aresetn), .clr(crc_clr), .upd(crc_upd),
        .din(crc_din), .crc(crc)
    );

    assign out_free      = !mv_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;

    // decode of the scanned frame
    logic [7:0]  f_fn;
    logic [16:0] off_w, size_w, end_w;
    logic        addr_ok, crc_ok, below_base;
    logic [15:0] idx_ext;
    logic        idx_ok;
    logic [LW-1:0] wlen;
    logic [8:0]  fa_hi, fa_lo;
    logic [16:0] toff;

    assign f_fn       = hdr_reg[1];
    assign below_base = off_reg < base_reg;
    assign off_w      = {1'b0, off_reg} - {1'b0, base_reg};
    assign size_w     = ({10'd0, inuse_reg} < 17'(TABLE_DEPTH)) ?
                        {10'd0, inuse_reg} : 17'(TABLE_DEPTH);
    assign end_w      = off_w + {1'b0, qty_reg};
    assign addr_ok    = hdr_reg[0] == slave_reg;
    assign crc_ok     = crc == {rxhi_reg, rxlo_reg};
    assign idx_ext    = 16'(in_index);
    assign idx_ok     = idx_ext < 16'(TABLE_DEPTH);
    assign wlen       = (flen_reg >= LW'(FRAME_BYTES)) ? '0 : flen_reg;
    assign fa_hi      = 9'd7 + {cnt_reg, 1'b0};
    assign fa_lo      = 9'd8 + {cnt_reg, 1'b0};
    assign toff       = {1'b0, off_reg} + {9'd0, cnt_reg};

    always_comb begin
        state_next = state_reg;
        flen_next  = flen_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        ticks_next = ticks_reg;
        alarm_next = alarm_reg;
        tv_next    = tv_reg;
        hdr_next   = hdr_reg;
        hlen_next  = hlen_reg;
        cnt_next   = cnt_reg;
        off_next   = off_reg;
        qty_next   = qty_reg;
        bc_next    = bc_reg;
        rxlo_next  = rxlo_reg;
        rxhi_next  = rxhi_reg;
        whi_next   = whi_reg;
        word_next  = word_reg;
        rdm_next   = rdm_reg;
        hok_next   = hok_reg;
        tvr_next   = tvr_reg;

        fr_we    = 1'b0;
        fr_waddr = wlen[FW-1:0];
        fr_raddr = pos_reg[FW-1:0];
        tb_we    = 1'b0;
        tb_waddr = idx_ext[TW-1:0];
        tb_wdata = in_value;
        tb_raddr = idx_ext[TW-1:0];

        crc_clr = 1'b0;
        crc_upd = 1'b0;
        crc_din = fr_rdata;

        emit    = 1'b0;
        e_kind  = KIND_TX;
        e_byte  = 8'd0;
        e_last  = 1'b0;
        e_alarm = alarm_reg;
        e_val   = 16'd0;

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    case (in_action)
                        ACT_RX_BYTE: begin
                            fr_we     = 1'b1;
                            flen_next = wlen + LW'(1);
                            ticks_next = 32'd0;
                        end
                        ACT_GAP: begin
                            flen_next = '0;
                            n_next    = flen_reg;
                            pos_next  = '0;
                            crc_clr   = 1'b1;
                            if (flen_reg >= LW'(8)) begin
                                state_next = S_SCAN_A;
                            end
                        end
                        ACT_TICK: begin
                            if (ticks_reg != 32'hFFFF_FFFF) begin
                                ticks_next = ticks_reg + 32'd1;
                            end
                            alarm_next = alarm_reg || (ticks_next > timeout_reg);
                            emit    = 1'b1;
                            e_kind  = KIND_STATUS;
                            e_last  = 1'b1;
                            e_alarm = alarm_next;
                        end
                        ACT_HWRITE: begin
                            if (idx_ok) begin
                                tb_we = 1'b1;
                                tv_next[tb_waddr] = 1'b1;
                            end
                        end
                        ACT_HREAD: begin
                            hok_next   = idx_ok;
                            tvr_next   = tv_reg[tb_raddr];
                            state_next = S_HREAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_HREAD: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = KIND_HREAD;
                    e_last     = 1'b1;
                    e_val      = (hok_reg && tvr_reg) ? tb_rdata : 16'd0;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_A: begin
                state_next = S_SCAN_B;
            end
            S_SCAN_B: begin
                // crc over all but the two trailing bytes
                crc_upd = pos_reg < (n_reg - LW'(2));
                case (pos_reg)
                    LW'(0): hdr_next[0] = fr_rdata;
                    LW'(1): hdr_next[1] = fr_rdata;
                    LW'(2): hdr_next[2] = fr_rdata;
                    LW'(3): hdr_next[3] = fr_rdata;
                    LW'(4): hdr_next[4] = fr_rdata;
                    LW'(5): hdr_next[5] = fr_rdata;
                    LW'(6): bc_next     = fr_rdata;
                    default: ;
                endcase
                if (pos_reg == n_reg - LW'(2)) begin
                    rxlo_next = fr_rdata;
                end
                if (pos_reg == n_reg - LW'(1)) begin
                    rxhi_next = fr_rdata;
                    off_next  = {hdr_reg[2], hdr_reg[3]};
                    qty_next  = {hdr_reg[4], hdr_reg[5]};
                    state_next = S_DECIDE;
                end else begin
                    pos_next   = pos_reg + LW'(1);
                    state_next = S_SCAN_A;
                end
            end
            S_DECIDE: begin
                // off_reg holds the bus start address here
                crc_clr  = 1'b1;
                cnt_next = 8'd0;
                rdm_next = 1'b0;
                hlen_next = 3'd3;
                hdr_next[0] = hdr_reg[0];
                hdr_next[1] = f_fn | FN_EXC_FLAG;
                state_next  = S_HDR;
                if (!addr_ok || !crc_ok) begin
                    state_next = S_IDLE;
                end else if (f_fn == FN_READ_HOLD) begin
                    if (qty_reg == 16'd0 || qty_reg > 16'(READ_CAP)) begin
                        hdr_next[2] = EXC_VALUE;
                    end else if (below_base || end_w > size_w) begin
                        hdr_next[2] = EXC_ADDRESS;
                    end else begin
                        hdr_next[1] = f_fn;
                        hdr_next[2] = {qty_reg[6:0], 1'b0};
                        off_next    = off_w[15:0];
                        rdm_next    = 1'b1;
                        alarm_next  = 1'b0;
                    end
                end else if (f_fn == FN_WRITE_ONE) begin
                    if (below_base || off_w >= size_w) begin
                        hdr_next[2] = EXC_ADDRESS;
                    end else begin
                        tb_we    = 1'b1;
                        tb_waddr = off_w[TW-1:0];
                        tb_wdata = qty_reg;
                        tv_next[tb_waddr] = 1'b1;
                        hdr_next[1] = f_fn;
                        hlen_next   = 3'd6;
                        alarm_next  = 1'b0;
                    end
                end else if (f_fn == FN_WRITE_MANY) begin
                    if ({1'b0, bc_reg} != 9'(n_reg) - 9'd9) begin
                        state_next = S_IDLE;
                    end else if (qty_reg == 16'd0 || qty_reg > 16'(WRITE_QTY_MAX) ||
                                 {9'd0, bc_reg} != {qty_reg, 1'b0}) begin
                        hdr_next[2] = EXC_VALUE;
                    end else if (below_base || end_w > size_w) begin
                        hdr_next[2] = EXC_ADDRESS;
                    end else begin
                        hdr_next[1] = f_fn;
                        hlen_next   = 3'd6;
                        off_next    = off_w[15:0];
                        alarm_next  = 1'b0;
                        state_next  = S_W_A;
                    end
                end else begin
                    hdr_next[2] = EXC_FUNCTION;
                end
            end
            S_W_A: begin
                fr_raddr   = fa_hi[FW-1:0];
                state_next = S_W_B;
            end
            S_W_B: begin
                whi_next   = fr_rdata;
                fr_raddr   = fa_lo[FW-1:0];
                state_next = S_W_C;
            end
            S_W_C: begin
                tb_we    = 1'b1;
                tb_waddr = toff[TW-1:0];
                tb_wdata = {whi_reg, fr_rdata};
                tv_next[tb_waddr] = 1'b1;
                if (cnt_reg + 8'd1 == qty_reg[7:0]) begin
                    cnt_next   = 8'd0;
                    state_next = S_HDR;
                end else begin
                    cnt_next   = cnt_reg + 8'd1;
                    state_next = S_W_A;
                end
            end
            S_HDR: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_byte  = hdr_reg[cnt_reg[2:0]];
                    crc_upd = 1'b1;
                    crc_din = e_byte;
                    if (cnt_reg[2:0] == hlen_reg - 3'd1) begin
                        cnt_next   = 8'd0;
                        state_next = rdm_reg ? S_T_A : S_CRC_LO;
                    end else begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
            end
            S_T_A: begin
                tb_raddr   = toff[TW-1:0];
                tvr_next   = tv_reg[tb_raddr];
                state_next = S_T_H;
            end
            S_T_H: begin
                // keep the read address so the word survives an output stall
                tb_raddr  = toff[TW-1:0];
                word_next = tvr_reg ? tb_rdata : 16'd0;
                if (out_free) begin
                    emit       = 1'b1;
                    e_byte     = word_next[15:8];
                    crc_upd    = 1'b1;
                    crc_din    = e_byte;
                    state_next = S_T_L;
                end
            end
            S_T_L: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_byte  = word_reg[7:0];
                    crc_upd = 1'b1;
                    crc_din = e_byte;
                    if (cnt_reg + 8'd1 == qty_reg[7:0]) begin
                        state_next = S_CRC_LO;
                    end else begin
                        cnt_next   = cnt_reg + 8'd1;
                        state_next = S_T_A;
                    end
                end
            end
            S_CRC_LO: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_byte     = crc[7:0];
                    state_next = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_byte     = crc[15:8];
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            flen_reg  <= '0;
            ticks_reg <= 32'd0;
            alarm_reg <= 1'b0;
            tv_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            flen_reg  <= flen_next;
            ticks_reg <= ticks_next;
            alarm_reg <= alarm_next;
            tv_reg    <= tv_next;
            if (emit) begin
                mv_reg <= 1'b1;
            end else if (m_axis_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        pos_reg  <= pos_next;
        hdr_reg  <= hdr_next;
        hlen_reg <= hlen_next;
        cnt_reg  <= cnt_next;
        off_reg  <= off_next;
        qty_reg  <= qty_next;
        bc_reg   <= bc_next;
        rxlo_reg <= rxlo_next;
        rxhi_reg <= rxhi_next;
        whi_reg  <= whi_next;
        word_reg <= word_next;
        rdm_reg  <= rdm_next;
        hok_reg  <= hok_next;
        tvr_reg  <= tvr_next;
        if (emit) begin
            mkind_reg  <= e_kind;
            mbyte_reg  <= e_byte;
            mlast_reg  <= e_last;
            malarm_reg <= e_alarm;
            mval_reg   <= e_val;
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tuser  = mkind_reg;
    assign m_axis_tlast  = mlast_reg;
    assign m_axis_tdata  = {7'd0, mval_reg, malarm_reg, mbyte_reg};
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import mbrs_pkg::*;

    typedef logic [7:0] bytes_t[$];

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic        alarm;
        logic [15:0] read_value;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // rx_byte[7:0], local_index[13:8], local_value[29:14]
    logic [2:0]  s_axis_tuser = '0;   // action[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // tx_byte[7:0], alarm[8], read_value[24:9]
    logic [1:0]  m_axis_tuser;        // kind[1:0]
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_register_slave uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // slave state as we expect it
    logic [7:0]  rx_frame [0:63];
    int          rx_len = 0;
    logic [15:0] hold_regs [0:63];
    logic        alarm_st = 1'b0;
    logic [31:0] silent_ticks = '0;
    logic [7:0]  cfg_slave = 8'd1;
    logic [15:0] cfg_base = 16'd0;
    logic [6:0]  cfg_inuse = 7'd64;
    logic [31:0] cfg_timeout = 32'd1000;

    result_t reply_expect_q[$];
    int      mismatches = 0;
    int      sent_items = 0;

    // flow control knobs
    int rx_wait = 0;
    int rx_hold = 0;
    bit rx_eager = 1'b0;
    bit tx_eager = 1'b0;

    function automatic logic [15:0] crc16(input bytes_t q);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (q[i]) begin
            c = c ^ {8'h00, q[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int exposed();
        return (cfg_inuse < 64) ? int'(cfg_inuse) : 64;
    endfunction

    task automatic push_result(logic [1:0] kind, logic [7:0] b, logic last,
                               logic [15:0] value);
        reply_expect_q.push_back('{kind, b, last, alarm_st, value});
    endtask

    // end-of-frame handling; replies go out as transmit-byte results
    task automatic model_frame_gap();
        bytes_t      rep;
        bytes_t      body;
        logic [15:0] c;
        logic [7:0]  fn;
        int          n, start, qty, off, size, code;
        n = rx_len;
        code = 0;
        if (n >= 8 && rx_frame[0] == cfg_slave) begin
            for (int i = 0; i < n - 2; i++) body.push_back(rx_frame[i]);
            c = crc16(body);
            if (c == {rx_frame[n-1], rx_frame[n-2]}) begin
                fn = rx_frame[1];
                start = {rx_frame[2], rx_frame[3]};
                qty = {rx_frame[4], rx_frame[5]};
                size = exposed();
                if (fn == FN_READ_HOLD) begin
                    if (qty == 0 || qty > 29) code = EXC_VALUE;
                    else if (start < cfg_base) code = EXC_ADDRESS;
                    else if (start - int'(cfg_base) + qty > size) code = EXC_ADDRESS;
                    else begin
                        off = start - int'(cfg_base);
                        rep = {rx_frame[0], rx_frame[1], 8'(2 * qty)};
                        for (int i = 0; i < qty; i++) begin
                            rep.push_back(hold_regs[off+i][15:8]);
                            rep.push_back(hold_regs[off+i][7:0]);
                        end
                        alarm_st = 1'b0;
                    end
                end else if (fn == FN_WRITE_ONE) begin
                    if (start < cfg_base || start - int'(cfg_base) >= size) code = EXC_ADDRESS;
                    else begin
                        hold_regs[start - int'(cfg_base)] = 16'(qty);
                        for (int i = 0; i < 6; i++) rep.push_back(rx_frame[i]);
                        alarm_st = 1'b0;
                    end
                end else if (fn == FN_WRITE_MANY) begin
                    // byte count must match the frame, else the frame is dropped
                    if (n >= 9 && int'(rx_frame[6]) == n - 9) begin
                        if (qty == 0 || qty > WRITE_QTY_MAX || int'(rx_frame[6]) != 2 * qty)
                            code = EXC_VALUE;
                        else if (start < cfg_base) code = EXC_ADDRESS;
                        else if (start - int'(cfg_base) + qty > size) code = EXC_ADDRESS;
                        else begin
                            off = start - int'(cfg_base);
                            for (int i = 0; i < qty; i++)
                                hold_regs[off+i] = {rx_frame[7+2*i], rx_frame[8+2*i]};
                            for (int i = 0; i < 6; i++) rep.push_back(rx_frame[i]);
                            alarm_st = 1'b0;
                        end
                    end
                end else begin
                    code = EXC_FUNCTION;
                end
                if (code != 0) rep = {cfg_slave, FN_EXC_FLAG | fn, 8'(code)};
            end
        end
        if (rep.size() > 0) begin
            c = crc16(rep);
            rep.push_back(c[7:0]);
            rep.push_back(c[15:8]);
        end
        foreach (rep[i]) push_result(KIND_TX, rep[i], i == rep.size() - 1, 16'h0);
        rx_len = 0;
    endtask

    task automatic model_transfer(logic [2:0] act, logic [7:0] b, logic [5:0] idx,
                                  logic [15:0] val);
        case (act)
            ACT_RX_BYTE: begin
                if (rx_len >= 64) rx_len = 0;
                rx_frame[rx_len] = b;
                rx_len++;
                silent_ticks = '0;
            end
            ACT_GAP: model_frame_gap();
            ACT_TICK: begin
                if (silent_ticks != 32'hFFFF_FFFF) silent_ticks++;
                if (silent_ticks > cfg_timeout) alarm_st = 1'b1;
                push_result(KIND_STATUS, 8'h0, 1'b1, 16'h0);
            end
            ACT_HWRITE: hold_regs[idx] = val;
            ACT_HREAD: push_result(KIND_HREAD, 8'h0, 1'b1, hold_regs[idx]);
            default: ;
        endcase
    endtask

    // one input transfer; tvalid stays high when the next item follows at once
    task automatic send_item(logic [2:0] act, logic [7:0] b, logic [5:0] idx,
                             logic [15:0] val);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {2'b00, val, idx, b};
        do @(posedge aclk); while (!s_axis_tready);
        sent_items++;
        model_transfer(act, b, idx, val);
    endtask

    task automatic send_frame(bytes_t q, bit corrupt);
        logic [15:0] c;
        c = crc16(q);
        if (corrupt) c[$urandom_range(0, 15)] ^= 1'b1;
        q.push_back(c[7:0]);
        q.push_back(c[15:8]);
        foreach (q[i]) send_item(ACT_RX_BYTE, q[i], 6'($urandom), 16'($urandom));
        send_item(ACT_GAP, 8'($urandom), 6'($urandom), 16'($urandom));
    endtask

    function automatic bytes_t plain_req(logic [7:0] a, logic [7:0] fn,
                                         logic [15:0] start, logic [15:0] qty);
        return {a, fn, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    endfunction

    function automatic bytes_t many_req(logic [7:0] a, logic [15:0] start,
                                        logic [15:0] qty, logic [7:0] cnt, int nbytes);
        bytes_t q;
        q = plain_req(a, FN_WRITE_MANY, start, qty);
        q.push_back(cnt);
        repeat (nbytes) q.push_back(8'($urandom));
        return q;
    endfunction

    // block must be idle: no results owed, and any silent frame scan finished
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (reply_expect_q.size() > 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SLAVE:   cfg_slave = v[7:0];
            REG_BASE:    cfg_base = v[15:0];
            REG_INUSE:   cfg_inuse = v[6:0];
            REG_TIMEOUT: cfg_timeout = v;
        endcase
    endtask

    task automatic set_config(logic [7:0] sa, logic [15:0] ba, logic [6:0] used,
                              logic [31:0] tmo);
        drain_all();
        cfg_write(REG_SLAVE, {24'h0, sa});
        cfg_write(REG_BASE, {16'h0, ba});
        cfg_write(REG_INUSE, {25'h0, used});
        cfg_write(REG_TIMEOUT, tmo);
    endtask

    // a request that mostly lands inside the exposed window
    task automatic random_good_frame();
        logic [15:0] start, qty;
        logic [7:0]  a;
        int          size;
        size = exposed();
        a = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_slave;
        start = cfg_base + 16'($urandom_range(0, size));
        if ($urandom_range(0, 7) == 0) start = 16'($urandom);
        qty = 16'($urandom_range(0, 10));
        if ($urandom_range(0, 9) == 0) qty = 16'($urandom_range(27, 31));
        case ($urandom_range(0, 3))
            0, 1: send_frame(plain_req(a, FN_READ_HOLD, start, qty), 1'b0);
            2:    send_frame(plain_req(a, FN_WRITE_ONE, start, 16'($urandom)), 1'b0);
            default: send_frame(many_req(a, start, qty, 8'(2 * qty), 2 * qty), 1'b0);
        endcase
    endtask

    task automatic test_host_access();
        send_item(ACT_HWRITE, 8'($urandom), 6'd0, 16'hFFFF);
        send_item(ACT_HWRITE, 8'($urandom), 6'd63, 16'h0000);
        send_item(ACT_HWRITE, 8'($urandom), 6'd5, 16'hA5A5);
        send_item(ACT_HWRITE, 8'($urandom), 6'd6, 16'h5A5A);
        send_item(ACT_HREAD, 8'($urandom), 6'd0, 16'($urandom));
        send_item(ACT_HREAD, 8'($urandom), 6'd63, 16'($urandom));
        send_item(ACT_HREAD, 8'($urandom), 6'd5, 16'($urandom));
        send_item(ACT_HREAD, 8'($urandom), 6'd7, 16'($urandom));
        // undefined action codes are dropped silently
        for (int a = 5; a < 8; a++)
            send_item(3'(a), 8'($urandom), 6'($urandom), 16'($urandom));
    endtask

    task automatic test_frames_directed();
        send_frame(plain_req(8'd1, FN_READ_HOLD, 16'd0, 16'd29), 1'b0);    // read cap
        send_frame(plain_req(8'd1, FN_READ_HOLD, 16'd0, 16'd0), 1'b0);     // zero qty
        send_frame(plain_req(8'd1, FN_READ_HOLD, 16'd0, 16'd30), 1'b0);    // over cap
        send_frame(plain_req(8'd1, FN_READ_HOLD, 16'd60, 16'd5), 1'b0);    // past end
        send_frame(plain_req(8'd1, FN_WRITE_ONE, 16'd63, 16'hBEEF), 1'b0);
        send_frame(plain_req(8'd1, FN_WRITE_ONE, 16'd64, 16'h1234), 1'b0);
        send_frame(many_req(8'd1, 16'd10, 16'd3, 8'd6, 6), 1'b0);
        send_frame(many_req(8'd1, 16'd10, 16'd0, 8'd0, 0), 1'b0);         // zero qty
        send_frame(many_req(8'd1, 16'd10, 16'd3, 8'd5, 5), 1'b0);         // count != 2*qty
        send_frame(many_req(8'd1, 16'd10, 16'd3, 8'd6, 4), 1'b0);         // count vs length
        send_frame(many_req(8'd1, 16'd62, 16'd3, 8'd6, 6), 1'b0);         // runs off end
        send_frame(plain_req(8'd2, FN_READ_HOLD, 16'd0, 16'd1), 1'b0);    // not ours
        send_frame(plain_req(8'd1, FN_READ_HOLD, 16'd0, 16'd1), 1'b1);    // bad crc
        send_frame(plain_req(8'd1, 8'h2B, 16'd0, 16'd1), 1'b0);           // unknown fn
        send_frame(plain_req(8'd1, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_frame(bytes_t'{8'd1, FN_READ_HOLD, 8'd0, 8'd0}, 1'b0);       // short frame
        send_frame(plain_req(8'd1, FN_READ_HOLD, 16'd10, 16'd3), 1'b0);
        send_item(ACT_GAP, 8'h0, 6'd0, 16'h0);                            // empty frame
    endtask

    task automatic test_comm_alarm();
        set_config(8'd1, 16'd0, 7'd64, 32'd2);
        repeat (4) send_item(ACT_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
        send_frame(plain_req(8'd1, 8'h41, 16'd0, 16'd1), 1'b0);   // exception keeps alarm
        send_item(ACT_HREAD, 8'h0, 6'd1, 16'h0);
        send_frame(plain_req(8'd1, FN_READ_HOLD, 16'd0, 16'd2), 1'b0);
        send_item(ACT_TICK, 8'h0, 6'd0, 16'h0);
        set_config(8'd1, 16'd0, 7'd64, 32'd0);
        send_item(ACT_TICK, 8'h0, 6'd0, 16'h0);
        send_frame(plain_req(8'd1, FN_WRITE_ONE, 16'd3, 16'h0F0F), 1'b0);
        send_item(ACT_TICK, 8'h0, 6'd0, 16'h0);
        set_config(8'd1, 16'd0, 7'd64, 32'hFFFF_FFFF);
        repeat (3) send_item(ACT_TICK, 8'h0, 6'd0, 16'h0);
    endtask

    task automatic test_config_sweep();
        logic [7:0]  sa [4] = '{8'd0, 8'd255, 8'd7, 8'd42};
        logic [15:0] ba [4] = '{16'd0, 16'hFFFF, 16'd100, 16'hFFC0};
        logic [6:0]  us [4] = '{7'd0, 7'd64, 7'd1, 7'd37};
        for (int k = 0; k < 4; k++) begin
            set_config(sa[k], ba[k], us[k], 32'($urandom_range(1, 30)));
            send_frame(plain_req(sa[k], FN_READ_HOLD, ba[k], 16'd1), 1'b0);
            send_frame(plain_req(sa[k], FN_WRITE_ONE, ba[k] - 16'd1, 16'h1111), 1'b0);
            random_good_frame();
        end
    endtask

    task automatic test_backpressure();
        drain_all();
        rx_hold = 300;
        tx_eager = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(ACT_HREAD, 8'h0, 6'($urandom), 16'h0);
        send_frame(plain_req(cfg_slave, FN_READ_HOLD, cfg_base, 16'd20), 1'b0);
        tx_eager = 1'b0;
        drain_all();
        // a stretch with no idling on either side
        rx_eager = 1'b1;
        tx_eager = 1'b1;
        repeat (2) random_good_frame();
        rx_eager = 1'b0;
        tx_eager = 1'b0;
    endtask

    task automatic test_random();
        int start_count;
        start_count = sent_items;
        set_config(8'h5A, 16'h0010, 7'd48, 32'd20);
        while (sent_items - start_count < 30) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: random_good_frame();
                6: send_item(ACT_TICK, 8'($urandom), 6'($urandom), 16'($urandom));
                7: send_item($urandom_range(0, 1) ? ACT_HWRITE : ACT_HREAD,
                             8'($urandom), 6'($urandom), 16'($urandom));
                8: send_item(3'($urandom), 8'($urandom), 6'($urandom), 16'($urandom));
                default: begin
                    case ($urandom_range(0, 2))
                        0: send_frame(plain_req(cfg_slave, FN_READ_HOLD, cfg_base,
                                                16'($urandom_range(1, 5))), 1'b1);
                        1: begin
                            // store overflows and wraps; the request after it still counts
                            repeat (64) send_item(ACT_RX_BYTE, 8'($urandom), 6'h0, 16'h0);
                            random_good_frame();
                        end
                        default: begin
                            repeat ($urandom_range(1, 12))
                                send_item(ACT_RX_BYTE, 8'($urandom), 6'h0, 16'h0);
                            send_item(ACT_GAP, 8'h0, 6'h0, 16'h0);
                        end
                    endcase
                end
            endcase
        end
    endtask

    // result side: random stalls, long hold-off when asked, in-order compare
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[8],
                        m_axis_tdata[24:9]};
                if (reply_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: kind %0d byte %h last %b alarm %b val %h",
                                 got.kind, got.tx_byte, got.last, got.alarm, got.read_value);
                end else begin
                    want = reply_expect_q.pop_front();
                    if (got.kind != want.kind || got.tx_byte != want.tx_byte ||
                        got.last != want.last || got.alarm != want.alarm ||
                        got.read_value != want.read_value) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp kind %0d byte %h last %b alarm %b val %h",
                                     want.kind, want.tx_byte, want.last, want.alarm,
                                     want.read_value);
                            $display("          got kind %0d byte %h last %b alarm %b val %h",
                                     got.kind, got.tx_byte, got.last, got.alarm,
                                     got.read_value);
                        end
                    end
                end
                rx_wait = rx_eager ? 0 : $urandom_range(0, 5);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_hold > 0) rx_hold--;
            m_axis_tready <= (rx_wait == 0 && rx_hold == 0);
        end
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        foreach (hold_regs[i]) hold_regs[i] = 16'h0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_host_access();
        test_frames_directed();
        test_comm_alarm();
        test_config_sweep();
        test_backpressure();
        test_random();
        drain_all();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[modbus_rtu_register_slave.f]
rtl/mbrs_pkg.sv
rtl/mbrs_ram.sv
rtl/mbrs_crc.sv
rtl/modbus_rtu_register_slave.sv
tb/testbench.sv
